[rtl/ttf_pkg.sv]
// shared widths, types and command structs for the triangle tangent frame block
package ttf_pkg;

  localparam int CoordW = 24;
  localparam int UvW    = 17;
  localparam int OutW   = 32;
  localparam int EdgeW  = CoordW + 1;
  localparam int DeltaW = UvW + 1;
  localparam int DetW   = 2 * DeltaW + 1;
  localparam int NumW   = EdgeW + DeltaW + 1;
  localparam int FracSh = 24;
  // dividend is |num| << 24, quotient keeps every dividend bit so overflow shows up top
  localparam int DivNW  = NumW + FracSh;
  localparam int QW     = DivNW;
  localparam int DivCntW = 7;
  localparam int InDataW  = 3 * CoordW + 2 * UvW;
  localparam int InBytesW = ((InDataW + 7) / 8) * 8;
  localparam int OutDataW = 6 * OutW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [UvW-1:0]    uv_t;

  // controller to datapath
  typedef struct packed {
    logic load0;
    logic load1;
    logic load2;
    logic calc_det;
    logic calc_num;
    logic div_start;
    logic [2:0] comp;
    logic result_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic det_zero;
  } dp_sts_t;

endpackage

[rtl/ttf_div.sv]
// serial restoring divider: rounded, saturated quotient of num * 2^24 / det
module ttf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [ttf_pkg::NumW-1:0] num,
  input  logic signed [ttf_pkg::DetW-1:0] det,
  output logic                            busy,
  output logic signed [ttf_pkg::OutW-1:0] quo
);
  localparam int NW = ttf_pkg::DivNW;
  localparam int DW = ttf_pkg::DetW;

  logic [NW-1:0] n_r, n_nxt;
  logic [DW:0]   rem_r, rem_nxt, d_r;
  logic [ttf_pkg::QW-1:0] q_r, q_nxt;
  logic [ttf_pkg::DivCntW-1:0] cnt_r;
  logic neg_r, busy_r, sat;
  logic [DW:0] trial;
  logic [ttf_pkg::QW:0] qr;
  logic [ttf_pkg::OutW-1:0] mag;
  logic [ttf_pkg::OutW-1:0] lim;

  assign trial = {rem_r[DW-1:0], n_r[NW-1]};

  always_comb begin
    n_nxt = {n_r[NW-2:0], 1'b0};
    if (trial >= d_r) begin
      rem_nxt = trial - d_r;
      q_nxt   = {q_r[ttf_pkg::QW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt   = {q_r[ttf_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ttf_pkg::DivCntW'(NW);
      neg_r  <= num[ttf_pkg::NumW-1] ^ det[DW-1];
      n_r    <= {(num[ttf_pkg::NumW-1] ? -num : num), {ttf_pkg::FracSh{1'b0}}};
      d_r    <= {1'b0, (det[DW-1] ? -det : det)};
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ttf_pkg::DivCntW'(1)) busy_r <= 1'b0;
    end
  end

  // round half up on magnitude, then saturate
  always_comb begin
    qr  = {1'b0, q_r} + {{ttf_pkg::QW{1'b0}}, ({rem_r, 1'b0} >= {1'b0, d_r})};
    lim = neg_r ? {1'b1, {(ttf_pkg::OutW-1){1'b0}}} : {1'b0, {(ttf_pkg::OutW-1){1'b1}}};
    sat = (q_r[ttf_pkg::QW-1:ttf_pkg::OutW] != '0) ||
          (qr > {{(ttf_pkg::QW+1-ttf_pkg::OutW){1'b0}}, lim});
    mag = sat ? lim : qr[ttf_pkg::OutW-1:0];
    quo = neg_r ? -mag : mag;
  end

  assign busy = busy_r;
endmodule

[rtl/ttf_datapath.sv]
// vertex registers, deltas, determinant, numerators, shared divider, result register
module ttf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ttf_pkg::dp_cmd_t               cmd,
  output ttf_pkg::dp_sts_t               sts,
  input  logic [ttf_pkg::InDataW-1:0]    vin,
  output logic [ttf_pkg::OutDataW-1:0]   res,
  output logic                           res_degen
);
  localparam int CW = ttf_pkg::CoordW;
  localparam int UW = ttf_pkg::UvW;

  ttf_pkg::coord_t p0_r [3], p1_r [3], p2_r [3];
  ttf_pkg::uv_t    t0_r [2], t1_r [2], t2_r [2];
  logic signed [ttf_pkg::DeltaW-1:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [ttf_pkg::EdgeW-1:0]  e1_r, e2_r;
  logic signed [ttf_pkg::DetW-1:0]   det_r;
  logic signed [ttf_pkg::NumW-1:0]   num_r, nt, nb;
  logic signed [ttf_pkg::NumW-1:0]   m1_r, m2_r;
  logic signed [ttf_pkg::OutW-1:0]   quo;
  logic [ttf_pkg::OutW-1:0] res_r [6];
  logic degen_r, busy;
  logic [1:0] ax;
  logic bt;

  // comp[2:1] axis, comp[0] selects bitangent
  assign ax = cmd.comp[2:1];
  assign bt = cmd.comp[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= '0;
        p1_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        t0_r[i] <= '0;
        t1_r[i] <= '0;
      end
      degen_r <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.load0) p0_r[i] <= vin[i*CW +: CW];
        if (cmd.load1) p1_r[i] <= vin[i*CW +: CW];
        if (cmd.load2) p2_r[i] <= vin[i*CW +: CW];
      end
      for (int i = 0; i < 2; i++) begin
        if (cmd.load0) t0_r[i] <= vin[3*CW+i*UW +: UW];
        if (cmd.load1) t1_r[i] <= vin[3*CW+i*UW +: UW];
        if (cmd.load2) t2_r[i] <= vin[3*CW+i*UW +: UW];
      end
      if (cmd.result_load) degen_r <= (det_r == '0);
    end
  end

  // deltas registered the cycle after the third vertex, determinant after that
  always_ff @(posedge clk) begin
    if (cmd.calc_det) begin
      du1_r <= $signed({1'b0, t1_r[0]}) - $signed({1'b0, t0_r[0]});
      dv1_r <= $signed({1'b0, t1_r[1]}) - $signed({1'b0, t0_r[1]});
      du2_r <= $signed({1'b0, t2_r[0]}) - $signed({1'b0, t0_r[0]});
      dv2_r <= $signed({1'b0, t2_r[1]}) - $signed({1'b0, t0_r[1]});
    end
    if (cmd.calc_num) begin
      det_r <= ttf_pkg::DetW'(du1_r) * ttf_pkg::DetW'(dv2_r) -
               ttf_pkg::DetW'(du2_r) * ttf_pkg::DetW'(dv1_r);
      e1_r  <= ttf_pkg::EdgeW'(p1_r[ax]) - ttf_pkg::EdgeW'(p0_r[ax]);
      e2_r  <= ttf_pkg::EdgeW'(p2_r[ax]) - ttf_pkg::EdgeW'(p0_r[ax]);
    end
  end

  // numerator: one product pair per step, registered before the subtract
  always_comb begin
    nt = ttf_pkg::NumW'(dv2_r) * ttf_pkg::NumW'(e1_r);
    nb = ttf_pkg::NumW'(du1_r) * ttf_pkg::NumW'(e2_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_num) begin
      m1_r <= '0;
      m2_r <= '0;
    end else if (!busy && !cmd.div_start) begin
      m1_r <= bt ? nb : nt;
      m2_r <= bt ? ttf_pkg::NumW'(du2_r) * ttf_pkg::NumW'(e1_r) :
                   ttf_pkg::NumW'(dv1_r) * ttf_pkg::NumW'(e2_r);
    end
    num_r <= m1_r - m2_r;
  end

  ttf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .det   (det_r),
    .busy  (busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_r[{1'b0, ax} + (bt ? 3'd3 : 3'd0)] <= (det_r == '0) ? '0 : quo;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) res[i*ttf_pkg::OutW +: ttf_pkg::OutW] = res_r[i];
  end

  assign res_degen    = degen_r;
  assign sts.div_busy = busy;
  assign sts.det_zero = (det_r == '0);
endmodule

[rtl/ttf_ctrl.sv]
// controller: vertex slot, per-component sequencing and output handshake
module ttf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ttf_pkg::dp_cmd_t  cmd,
  input  ttf_pkg::dp_sts_t  sts
);
  typedef enum logic [2:0] {
    S_IN, S_DELTA, S_AXIS, S_MUL, S_SUB, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] slot_r;
  logic [2:0] comp_r;
  logic out_valid_r;

  assign in_ready  = (state_r == S_IN);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.comp        = comp_r;
    cmd.load0       = in_fire && (slot_r == 2'd0);
    cmd.load1       = in_fire && (slot_r == 2'd1);
    cmd.load2       = in_fire && (slot_r == 2'd2);
    cmd.calc_det    = (state_r == S_DELTA);
    cmd.calc_num    = (state_r == S_AXIS);
    cmd.div_start   = (state_r == S_DIV);
    cmd.result_load = (state_r == S_WAIT) && !sts.div_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      slot_r      <= 2'd0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IN: begin
          if (in_fire) begin
            if (slot_r == 2'd2) begin
              slot_r  <= 2'd0;
              comp_r  <= '0;
              state_r <= S_DELTA;
            end else begin
              slot_r <= slot_r + 2'd1;
            end
          end
        end
        S_DELTA: state_r <= S_AXIS;
        S_AXIS:  state_r <= S_MUL;
        S_MUL:   state_r <= S_SUB;
        S_SUB:   state_r <= S_DIV;
        S_DIV:   state_r <= S_WAIT;
        S_WAIT: begin
          if (!sts.div_busy) begin
            if (comp_r == 3'b101) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              comp_r  <= comp_r[0] ? {comp_r[2:1] + 2'd1, 1'b0} : {comp_r[2:1], 1'b1};
              state_r <= comp_r[0] ? S_AXIS : S_MUL;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IN;
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end
endmodule

[rtl/triangle_tangent_frame_core.sv]
// top level of the triangle tangent frame core
// Vertices arrive one beat each; the first two are stored.
// The third beat starts the frame computation: the texture deltas and the
// determinant are formed, then six quotients (tangent x,y,z and bitangent x,y,z)
// run one after the other through a single serial restoring divider of 68
// iterations, each with its operand steps around it; after the sixth quotient
// the result beat is offered. The divider iterations take most of the time of a
// triangle. The result beat holds until taken; the input is not taken while a
// triangle is in the divider or its result waits.
// A zero texture determinant yields zero vectors with degenerate set.
module triangle_tangent_frame_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], tex_u[88:72], tex_v[105:89], zero fill
  input  logic [ttf_pkg::InBytesW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z, 32 bits each
  output logic [ttf_pkg::OutDataW-1:0]   out_tdata,
  // degenerate
  output logic                           out_tuser
);
  ttf_pkg::dp_cmd_t cmd;
  ttf_pkg::dp_sts_t sts;
  logic in_fire;

  // beat accepted on the input side
  assign in_fire = in_tvalid && in_tready;

  ttf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .vin       (in_tdata[ttf_pkg::InDataW-1:0]),
    .res       (out_tdata),
    .res_degen (out_tuser)
  );
endmodule

[rtl/ttf_checker.sv]
// port-level checker for the triangle tangent frame core, with its bind
module ttf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [ttf_pkg::OutDataW-1:0] out_tdata,
  input logic                         out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero vectors");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind triangle_tangent_frame_core ttf_checker u_ttf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/tb_triangle_tangent_frame_core.sv]
// self-checking testbench for the triangle tangent frame core
module tb_triangle_tangent_frame_core;

  localparam int WatchdogCycles = 20000;
  localparam int DrainCycles    = 600;

  typedef struct packed {
    logic [31:0] tan_x;
    logic [31:0] tan_y;
    logic [31:0] tan_z;
    logic [31:0] bitan_x;
    logic [31:0] bitan_y;
    logic [31:0] bitan_z;
    logic        degen;
  } frame_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [ttf_pkg::InBytesW-1:0] in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [ttf_pkg::OutDataW-1:0] out_tdata;
  logic                         out_tuser;

  // expected frames, oldest first
  frame_t frame_q[$];
  int     mismatch_cnt = 0;
  int     idle_cycles = 0;
  int     hold_off = 0;
  int     burst_left = 0;

  // predictor state: vertices 0 and 1 of the triangle being collected
  int              corner_cnt = 0;
  ttf_pkg::coord_t corner0_pos[3];
  ttf_pkg::coord_t corner1_pos[3];
  ttf_pkg::uv_t    corner0_uv[2];
  ttf_pkg::uv_t    corner1_uv[2];

  always #5 clk = ~clk;

  triangle_tangent_frame_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // rounded quotient num * 2^24 / den, saturated to signed 32 bits
  function automatic logic [31:0] q16_quotient(longint num, longint den);
    logic            neg;
    longint unsigned n, d, lim, q, r;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q = n / d;
    r = n % d;
    if (q >= 64'd8388608) begin
      q = lim;
    end else begin
      for (int i = 0; i < ttf_pkg::FracSh; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
      end
      // ties go away from zero
      if ((r << 1) >= d) q = q + 64'd1;
      if (q > lim) q = lim;
    end
    if (neg) q = -q;
    return q[31:0];
  endfunction

  // returns 1 and the frame when this vertex closes a triangle
  function automatic bit tangent_frame_of(input ttf_pkg::coord_t pos[3],
                                          input ttf_pkg::uv_t uv[2],
                                          output frame_t fr);
    longint du1, dv1, du2, dv2, det, p0, e1, e2;
    logic [31:0] tan[3];
    logic [31:0] bit_v[3];
    if (corner_cnt == 0) begin
      corner0_pos = pos;
      corner0_uv  = uv;
      corner_cnt  = 1;
      return 1'b0;
    end
    if (corner_cnt == 1) begin
      corner1_pos = pos;
      corner1_uv  = uv;
      corner_cnt  = 2;
      return 1'b0;
    end
    du1 = longint'(corner1_uv[0]) - longint'(corner0_uv[0]);
    dv1 = longint'(corner1_uv[1]) - longint'(corner0_uv[1]);
    du2 = longint'(uv[0]) - longint'(corner0_uv[0]);
    dv2 = longint'(uv[1]) - longint'(corner0_uv[1]);
    det = du1 * dv2 - du2 * dv1;
    for (int i = 0; i < 3; i++) begin
      p0 = longint'(corner0_pos[i]);
      e1 = longint'(corner1_pos[i]) - p0;
      e2 = longint'(pos[i]) - p0;
      if (det == 0) begin
        tan[i]   = '0;
        bit_v[i] = '0;
      end else begin
        tan[i]   = q16_quotient(dv2 * e1 - dv1 * e2, det);
        bit_v[i] = q16_quotient(du1 * e2 - du2 * e1, det);
      end
    end
    fr = '{tan[0], tan[1], tan[2], bit_v[0], bit_v[1], bit_v[2], det == 0};
    corner_cnt = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // one vertex beat, with the sender working in bursts
  task automatic send_vertex(ttf_pkg::coord_t px, ttf_pkg::coord_t py, ttf_pkg::coord_t pz,
                             ttf_pkg::uv_t u, ttf_pkg::uv_t v);
    ttf_pkg::coord_t pos[3];
    ttf_pkg::uv_t    uv[2];
    frame_t          fr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ttf_pkg::InBytesW - ttf_pkg::InDataW){1'b0}}, v, u, pz, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pos = '{px, py, pz};
    uv  = '{u, v};
    if (tangent_frame_of(pos, uv, fr)) frame_q = {frame_q, fr};
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // sender pauses until every frame is back
  task automatic wait_all_frames();
    release_input();
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  function automatic ttf_pkg::coord_t rand_coord();
    return ttf_pkg::coord_t'($urandom());
  endfunction

  task automatic send_random_triangle(bit narrow_uv);
    ttf_pkg::uv_t u0, v0;
    u0 = ttf_pkg::uv_t'($urandom_range(0, 65536));
    v0 = ttf_pkg::uv_t'($urandom_range(0, 65536));
    for (int k = 0; k < 3; k++) begin
      if (narrow_uv)
        send_vertex(rand_coord(), rand_coord(), rand_coord(),
                    ttf_pkg::uv_t'(u0 + $urandom_range(0, 64)),
                    ttf_pkg::uv_t'(v0 + $urandom_range(0, 64)));
      else if ($urandom_range(0, 9) == 0)
        // full 17-bit texcoords, above 1.0 included
        send_vertex(rand_coord(), rand_coord(), rand_coord(),
                    ttf_pkg::uv_t'($urandom()), ttf_pkg::uv_t'($urandom()));
      else
        send_vertex(ttf_pkg::coord_t'($urandom_range(0, 4095)) - ttf_pkg::coord_t'(2048),
                    rand_coord(), ttf_pkg::coord_t'($urandom_range(0, 65535)),
                    ttf_pkg::uv_t'($urandom_range(0, 65536)),
                    ttf_pkg::uv_t'($urandom_range(0, 65536)));
    end
  endtask

  task automatic test_basic_frame();
    // unit right triangle, tangent along x and bitangent along y
    send_vertex(24'sd0,   24'sd0,   24'sd0, 17'd0,     17'd0);
    send_vertex(24'sd256, 24'sd0,   24'sd0, 17'd65536, 17'd0);
    send_vertex(24'sd0,   24'sd256, 24'sd0, 17'd0,     17'd65536);
    wait_all_frames();
  endtask

  task automatic test_degenerate();
    // equal texcoords give a zero determinant
    send_vertex(24'sd100, 24'sd200, 24'sd300, 17'd1000, 17'd1000);
    send_vertex(24'sd400, 24'sd500, 24'sd600, 17'd1000, 17'd1000);
    send_vertex(24'sd700, 24'sd800, 24'sd900, 17'd1000, 17'd1000);
    // collinear texcoords
    send_vertex(24'sd1, 24'sd2, 24'sd3, 17'd0,     17'd0);
    send_vertex(24'sd4, 24'sd5, 24'sd6, 17'd100,   17'd100);
    send_vertex(24'sd7, 24'sd8, 24'sd9, 17'd200,   17'd200);
  endtask

  task automatic test_extremes();
    // widest edges with tiny uv deltas: saturation both ways
    send_vertex(24'sh800000, 24'sh7fffff, 24'sh800000, 17'd0, 17'd0);
    send_vertex(24'sh7fffff, 24'sh800000, 24'sh800000, 17'd1, 17'd0);
    send_vertex(24'sh800000, 24'sh800000, 24'sh7fffff, 17'd0, 17'd1);
    // texcoords at 0, 1.0 and the top of the field
    send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 17'd0,      17'h1ffff);
    send_vertex(24'sh000001, 24'shffffff, 24'sh400000, 17'h1ffff, 17'd0);
    send_vertex(24'sh800000, 24'sh000000, 24'shc00000, 17'd65536, 17'd65536);
    // tiny triangle with the largest uv spread
    send_vertex(24'sd0, 24'sd0, 24'sd0, 17'd0,     17'd0);
    send_vertex(24'sd1, 24'sd0, -24'sd1, 17'h1ffff, 17'd0);
    send_vertex(24'sd0, 24'sd1, 24'sd1, 17'd0,     17'h1ffff);
    wait_all_frames();
  endtask

  task automatic test_output_backpressure();
    // receiver holds off well past one frame while the sender keeps offering vertices
    hold_off = 2000;
    for (int t = 0; t < 4; t++) send_random_triangle(1'b0);
    wait_all_frames();
  endtask

  task automatic test_random_triangles(int tri_cnt);
    for (int t = 0; t < tri_cnt; t++) begin
      send_random_triangle($urandom_range(0, 4) == 0);
      if (t == tri_cnt / 2) wait_all_frames();
    end
    release_input();
  endtask

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    int mode;
    if (hold_off > 0) begin
      hold_off--;
      out_tready <= 1'b0;
    end else begin
      mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checking at the rising edge
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], 32'd0);
      end else begin
        want = frame_q.pop_front();
        if (out_tdata[31:0] !== want.tan_x) report_mismatch("tangent_x", out_tdata[31:0], want.tan_x);
        if (out_tdata[63:32] !== want.tan_y) report_mismatch("tangent_y", out_tdata[63:32], want.tan_y);
        if (out_tdata[95:64] !== want.tan_z) report_mismatch("tangent_z", out_tdata[95:64], want.tan_z);
        if (out_tdata[127:96] !== want.bitan_x)
          report_mismatch("bitangent_x", out_tdata[127:96], want.bitan_x);
        if (out_tdata[159:128] !== want.bitan_y)
          report_mismatch("bitangent_y", out_tdata[159:128], want.bitan_y);
        if (out_tdata[191:160] !== want.bitan_z)
          report_mismatch("bitangent_z", out_tdata[191:160], want.bitan_z);
        if (out_tuser !== want.degen)
          report_mismatch("degenerate", 32'(out_tuser), 32'(want.degen));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogCycles) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_basic_frame();
    test_degenerate();
    test_extremes();
    test_output_backpressure();
    test_random_triangles(170);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ttf_pkg.sv
rtl/ttf_div.sv
rtl/ttf_datapath.sv
rtl/ttf_ctrl.sv
rtl/triangle_tangent_frame_core.sv
rtl/ttf_checker.sv
tb/tb_triangle_tangent_frame_core.sv
